// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ssbs_pkg.sv =====
// constants, segment tables and digit helpers for the bargraph serializer
// no dependencies

package ssbs_pkg;

    localparam int VALUE_W   = 16;
    localparam int LEVEL_W   = 4;
    localparam int WORD_W    = 32;
    localparam int BITNUM_W  = 5;
    localparam int HALF_W    = 16;
    localparam int DIGIT_W   = 4;
    localparam int PROD_W    = 33;

    // reciprocal constants, exact for every 16-bit value
    localparam logic [PROD_W-1:0] RECIP_10   = 33'd52429;
    localparam int                SHIFT_10   = 19;
    localparam logic [PROD_W-1:0] RECIP_100  = 33'd83887;
    localparam int                SHIFT_100  = 23;
    localparam logic [PROD_W-1:0] RECIP_1000 = 33'd67109;
    localparam int                SHIFT_1000 = 26;

    localparam logic [LEVEL_W-1:0]  BAR_MAX  = 4'd8;
    localparam logic [BITNUM_W-1:0] LAST_BIT = 5'(WORD_W - 1);

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [WORD_W-1:0] t_word;

    // hundreds and ones positions
    function automatic t_half outer_seg(input logic [DIGIT_W-1:0] d);
        t_half s;
        case (d)
            4'd0:    s = 16'h7007;
            4'd1:    s = 16'h4001;
            4'd2:    s = 16'h300B;
            4'd3:    s = 16'h600B;
            4'd4:    s = 16'h400D;
            4'd5:    s = 16'h600E;
            4'd6:    s = 16'h700E;
            4'd7:    s = 16'h4003;
            4'd8:    s = 16'h700F;
            4'd9:    s = 16'h600F;
            default: s = '0;
        endcase
        return s;
    endfunction

    // tens position
    function automatic t_half middle_seg(input logic [DIGIT_W-1:0] d);
        t_half s;
        case (d)
            4'd0:    s = 16'h0770;
            4'd1:    s = 16'h0410;
            4'd2:    s = 16'h03B0;
            4'd3:    s = 16'h06B0;
            4'd4:    s = 16'h04D0;
            4'd5:    s = 16'h06E0;
            4'd6:    s = 16'h07E0;
            4'd7:    s = 16'h0430;
            4'd8:    s = 16'h07F0;
            4'd9:    s = 16'h06F0;
            default: s = '0;
        endcase
        return s;
    endfunction

    // bar leds, levels above eight saturate
    function automatic t_half bar_seg(input logic [LEVEL_W-1:0] lvl);
        t_half s;
        case (lvl) inside
            4'd0:         s = 16'h0000;
            4'd1:         s = 16'h0100;
            4'd2:         s = 16'h0300;
            4'd3:         s = 16'h0700;
            4'd4:         s = 16'h0F00;
            4'd5:         s = 16'h0F80;
            4'd6:         s = 16'h0FC0;
            4'd7:         s = 16'h0FE0;
            [4'd8:4'd15]: s = 16'h0FF0;
            default:      s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/ssbs_if.sv =====
// valid/ready channel interfaces for the bargraph serializer
// depends on ssbs_pkg

interface ssbs_in_if
    import ssbs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] display_value;
    logic [LEVEL_W-1:0] bar_level;

    modport source (output valid, output display_value, output bar_level, input ready);
    modport sink   (input valid, input display_value, input bar_level, output ready);
endinterface

interface ssbs_out_if
    import ssbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                serial_data;
    logic [BITNUM_W-1:0] bit_number;
    logic                latch_strobe;

    modport source (output valid, output serial_data, output bit_number,
                    output latch_strobe, input ready);
    modport sink   (input valid, input serial_data, input bit_number,
                    input latch_strobe, output ready);
endinterface

// ===== hw/rtl/seven_segment_bargraph_serializer_top.sv =====
// seven-segment and bar-graph word builder with lsb-first serial output
// depends on ssbs_pkg and ssbs_if
//
// channel  dir  payload                                   transfer
// i_in     in   display_value[15:0], bar_level[3:0]        valid && ready
// o_out    out  serial_data, bit_number[4:0], latch_strobe valid && ready
//
// each item gives 32 results, one per cycle while the output is ready
// the rate is set by the single-bit output shifter; the word is built combinationally
// an item waits in the input register while the previous word shifts out
// reset is synchronous active low and clears both valid flags
// output stalls hold the shifter; the input register fills and then drops ready

module seven_segment_bargraph_serializer_top
    import ssbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssbs_in_if.sink    i_in,
    ssbs_out_if.source o_out
);

    logic               r_in_valid;
    logic [VALUE_W-1:0] r_value;
    logic [LEVEL_W-1:0] r_level;

    t_word               r_shift;
    logic [BITNUM_W-1:0] r_bit_cnt;
    logic                r_out_valid;

    logic [PROD_W-1:0]   prod_10, prod_100, prod_1000;
    logic [12:0]         q10;
    logic [9:0]          q100;
    logic [6:0]          q1000;
    logic [VALUE_W-1:0]  rem_ones;
    logic [12:0]         rem_tens;
    logic [9:0]          rem_hund;
    logic [DIGIT_W-1:0]  d_ones, d_tens, d_hund;
    t_word               n_word;

    logic                out_xfer, last_bit, load_word, in_xfer;

    // digit split by reciprocal multiplication
    always_comb begin
        prod_10   = PROD_W'(r_value) * RECIP_10;
        prod_100  = PROD_W'(r_value) * RECIP_100;
        prod_1000 = PROD_W'(r_value) * RECIP_1000;
        q10       = prod_10[SHIFT_10 +: 13];
        q100      = prod_100[SHIFT_100 +: 10];
        q1000     = prod_1000[SHIFT_1000 +: 7];
        rem_ones  = r_value - VALUE_W'(q10) * 16'd10;
        rem_tens  = q10 - 13'(q100) * 13'd10;
        rem_hund  = q100 - 10'(q1000) * 10'd10;
        d_ones    = rem_ones[DIGIT_W-1:0];
        d_tens    = rem_tens[DIGIT_W-1:0];
        d_hund    = rem_hund[DIGIT_W-1:0];
        n_word    = {outer_seg(d_hund) | bar_seg(r_level),
                     middle_seg(d_tens) | outer_seg(d_ones)};
    end

    assign last_bit  = (r_bit_cnt == LAST_BIT);
    assign out_xfer  = r_out_valid && o_out.ready;
    assign load_word = r_in_valid && (!r_out_valid || (out_xfer && last_bit));
    assign i_in.ready = !r_in_valid || load_word;
    assign in_xfer   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (load_word) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_value <= i_in.display_value;
            r_level <= i_in.bar_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bit_cnt   <= '0;
        end else if (load_word) begin
            r_out_valid <= 1'b1;
            r_bit_cnt   <= '0;
        end else if (out_xfer) begin
            if (last_bit) begin
                r_out_valid <= 1'b0;
            end
            r_bit_cnt <= r_bit_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_word) begin
            r_shift <= n_word;
        end else if (out_xfer) begin
            r_shift <= {1'b0, r_shift[WORD_W-1:1]};
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.serial_data  = r_shift[0];
    assign o_out.bit_number   = r_bit_cnt;
    assign o_out.latch_strobe = last_bit;

endmodule

// ===== hw/rtl/ssbs_checker.sv =====
// port-level checks for the bargraph serializer, bound to the top level
// depends on ssbs_pkg and assert_macros.svh

`include "assert_macros.svh"

module ssbs_checker
    import ssbs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [BITNUM_W-1:0] i_bit_number,
    input logic                i_latch_strobe
);

    `ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid)
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_bit_number))
    `ASSERT_NEXT(a_bits_in_order, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_latch_strobe, i_out_valid && (i_bit_number == $past(i_bit_number) + 5'd1))
    `ASSERT_IMPLY(a_strobe_on_last, i_clk, i_rst_n, i_out_valid, i_latch_strobe == (i_bit_number == LAST_BIT))
    `ASSERT_NEXT(a_word_starts_at_zero, i_clk, i_rst_n, i_out_valid && i_out_ready && i_latch_strobe, !i_out_valid || (i_bit_number == 5'd0))

endmodule

bind seven_segment_bargraph_serializer_top ssbs_checker u_ssbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_bit_number   (o_out.bit_number),
    .i_latch_strobe (o_out.latch_strobe)
);

// ===== sim/tb_top.sv =====
// testbench for the seven-segment bargraph serializer: predicts the 32-bit display word
// for each transfer and checks every serial bit in order; depends on ssbs_pkg and ssbs_if
`timescale 1ns / 1ps

module tb_top;
    import ssbs_pkg::*;

    typedef struct packed {
        logic                serial_data;
        logic [BITNUM_W-1:0] bit_number;
        logic                latch_strobe;
    } t_serial_bit;

    // hundreds and ones positions
    localparam t_half OUTER_SEG_TBL [0:9] = '{
        16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
        16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
    };
    // tens position
    localparam t_half MIDDLE_SEG_TBL [0:9] = '{
        16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
        16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
    };
    // lit bar count 0..8
    localparam t_half BAR_SEG_TBL [0:8] = '{
        16'h0000, 16'h0100, 16'h0300, 16'h0700, 16'h0F00,
        16'h0F80, 16'h0FC0, 16'h0FE0, 16'h0FF0
    };

    logic clk = 1'b0;
    logic rst_n;

    ssbs_in_if  in_ch ();
    ssbs_out_if out_ch ();

    seven_segment_bargraph_serializer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_serial_bit pending_bits [$];
    int unsigned mismatches = 0;
    bit          no_idle    = 1'b0;

    always #5 clk = ~clk;

    function automatic t_word predict_display_word(input logic [VALUE_W-1:0] value,
                                                   input logic [LEVEL_W-1:0] level);
        int unsigned hundreds;
        int unsigned tens;
        int unsigned ones;
        int unsigned lit;
        hundreds = (int'(value) / 100) % 10;
        tens     = (int'(value) / 10) % 10;
        ones     = int'(value) % 10;
        lit      = (level > BAR_MAX) ? int'(BAR_MAX) : int'(level);
        return {OUTER_SEG_TBL[hundreds] | BAR_SEG_TBL[lit],
                MIDDLE_SEG_TBL[tens] | OUTER_SEG_TBL[ones]};
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [LEVEL_W-1:0] level);
        int unsigned gap;
        t_word       word;
        t_serial_bit sb;
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.display_value <= value;
        in_ch.bar_level     <= level;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        word = predict_display_word(value, level);
        for (int k = 0; k < WORD_W; k++) begin
            sb.serial_data  = word[k];
            sb.bit_number   = BITNUM_W'(k);
            sb.latch_strobe = (BITNUM_W'(k) == LAST_BIT);
            pending_bits.push_back(sb);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge clk);
    endtask

    // value d*111 puts digit d in every position
    task automatic test_all_digits();
        for (int d = 0; d < 10; d++)
            send_number(VALUE_W'(d * 111), LEVEL_W'(d % 8));
        wait_idle();
    endtask

    task automatic test_thousands_dropped();
        logic [VALUE_W-1:0] vals [0:5];
        vals = '{16'd1000, 16'd9999, 16'd10000, 16'd54321, 16'd65535, 16'd32768};
        foreach (vals[i])
            send_number(vals[i], LEVEL_W'($urandom_range(0, 7)));
        wait_idle();
    endtask

    task automatic test_bar_saturation();
        for (int lvl = 8; lvl < 16; lvl++)
            send_number(16'd888, LEVEL_W'(lvl));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned        r;
        logic [VALUE_W-1:0] value;
        repeat (count) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                value = VALUE_W'($urandom_range(0, 999));
            else if (r < 9)
                value = VALUE_W'($urandom);
            else
                value = VALUE_W'($urandom_range(0, 1) ? 999 + $urandom_range(0, 2)
                                                      : 65535 - $urandom_range(0, 2));
            send_number(value, LEVEL_W'($urandom_range(0, 15)));
        end
        wait_idle();
    endtask

    // sustained rate, no gaps on either side
    task automatic test_back_to_back(input int unsigned count);
        no_idle = 1'b1;
        repeat (count)
            send_number(VALUE_W'($urandom), LEVEL_W'($urandom_range(0, 15)));
        wait_idle();
        no_idle = 1'b0;
    endtask

    // result side stalls
    initial begin
        int unsigned on_len;
        int unsigned off_len;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
            out_ch.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            off_len = pick_gap();
            if (off_len != 0) begin
                out_ch.ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : check_serial_bits
        t_serial_bit want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected transfer expected none actual bit %0d data %b",
                         $time, out_ch.bit_number, out_ch.serial_data);
                mismatches++;
            end else begin
                want = pending_bits.pop_front();
                compare_field("serial_data", 8'(want.serial_data), 8'(out_ch.serial_data));
                compare_field("bit_number", 8'(want.bit_number), 8'(out_ch.bit_number));
                compare_field("latch_strobe", 8'(want.latch_strobe), 8'(out_ch.latch_strobe));
            end
        end
    end

    initial begin
        #50_000_000;
        $display("seven_segment_bargraph_serializer_top: mismatch");
        $finish;
    end

    initial begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.display_value <= '0;
        in_ch.bar_level     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_all_digits();
        test_thousands_dropped();
        test_bar_saturation();
        test_random_traffic(260);
        test_back_to_back(40);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("seven_segment_bargraph_serializer_top: match");
        else
            $display("seven_segment_bargraph_serializer_top: mismatch");
        $finish;
    end

endmodule

// ===== seven_segment_bargraph_serializer_top.f =====
+incdir+hw/rtl
hw/rtl/ssbs_pkg.sv
hw/rtl/ssbs_if.sv
hw/rtl/seven_segment_bargraph_serializer_top.sv
hw/rtl/ssbs_checker.sv
sim/tb_top.sv
